FILE: hw/rtl/caf_lpcm_stream_parser_macros.svh
// Assertion macros used by the CAF stream parser top level.
`ifndef CAF_LPCM_STREAM_PARSER_MACROS_SVH
`define CAF_LPCM_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define CAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("caf parser check failed");

// Next-cycle implication, sampled on aclk and held off during reset.
`define CAF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("caf parser check failed");

`endif

FILE: hw/rtl/caflpcm_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package caflpcm_pkg;

    localparam int unsigned CafHeaderSize      = 8;
    localparam int unsigned CafChunkHeaderSize = 12;
    localparam int unsigned CafDescSize        = 32;
    localparam int unsigned CafEditCountSize   = 4;
    localparam logic [31:0] LpcmFlags          = 32'd2;
    localparam logic [31:0] BitsPerChannel     = 32'd16;

    localparam logic [31:0] TAG_CAFF = 32'h6361_6666;
    localparam logic [31:0] TAG_DESC = 32'h6465_7363;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_LPCM = 32'h6C70_636D;

    localparam int unsigned OutDataW = 69;

    // File walk phases.
    localparam logic [1:0] PH_FILE    = 2'd0;
    localparam logic [1:0] PH_CHUNK   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Verdict status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_SIG   = 4'd1;
    localparam logic [3:0] ST_BAD_DESC  = 4'd2;
    localparam logic [3:0] ST_TRUNC     = 4'd3;
    localparam logic [3:0] ST_SHORT     = 4'd4;
    localparam logic [3:0] ST_NO_DESC   = 4'd5;
    localparam logic [3:0] ST_NO_SAMP   = 4'd6;
    localparam logic [3:0] ST_ODD       = 4'd7;
    localparam logic [3:0] ST_NOT_WHOLE = 4'd8;

    typedef struct packed {
        logic accept;
        logic desc_check;
        logic mod_load;
        logic mod_step;
        logic load_verdict;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic samp_pend;
    } stat_t;

endpackage

FILE: hw/rtl/caflpcm_dp.sv
// Datapath: file walk registers, desc store, rate rounding, modulo unit, output register.
module caflpcm_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  caflpcm_pkg::cmd_t    cmd,
    output caflpcm_pkg::stat_t   stat,
    input  logic [7:0]           in_byte,
    output logic                 out_kind,
    output logic [caflpcm_pkg::OutDataW-1:0] out_data
);
    import caflpcm_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [31:0] tag_reg, tag_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] left_reg, left_next;
    logic [5:0]  pos_reg, pos_next;
    logic        par_reg, par_next;
    logic        have_reg, have_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] ch_reg, ch_next;
    logic        seen_reg, seen_next;
    logic [63:0] bytes_reg, bytes_next;
    logic [7:0]  low_reg, low_next;
    logic [3:0]  err_reg, err_next;
    logic        dpend_reg, dpend_next;
    logic        spend_reg, spend_next;
    logic [16:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [OutDataW-1:0] odata_reg, odata_next;
    logic        okind_reg, okind_next;

    logic [7:0]  desc_mem [CafDescSize];
    logic        wr_en;
    logic [4:0]  wr_addr;

    logic [63:0] len_hdr;
    logic        fin;
    logic [63:0] fin_len;
    logic [7:0]  sig_byte;

    // Desc fields and rounding.
    logic [63:0] bits;
    logic [31:0] fmt, flags, pkt, chv, bpc;
    logic [10:0] ex;
    logic [52:0] man;
    logic [5:0]  sh;
    logic [53:0] man_rnd;
    logic [53:0] man_shr;
    logic        desc_bad;

    logic [17:0] mod_t;
    logic [16:0] divisor;
    logic [3:0]  st;

    assign len_hdr = {len_reg[55:0], in_byte};
    assign divisor = {ch_reg, 1'b0};
    assign mod_t   = {rem_reg, quo_reg[63]};

    always_comb begin
        unique case (hidx_reg[1:0])
            2'd0:    sig_byte = TAG_CAFF[31:24];
            2'd1:    sig_byte = TAG_CAFF[23:16];
            2'd2:    sig_byte = TAG_CAFF[15:8];
            default: sig_byte = TAG_CAFF[7:0];
        endcase
    end

    always_comb begin
        bits  = {desc_mem[0], desc_mem[1], desc_mem[2], desc_mem[3],
                 desc_mem[4], desc_mem[5], desc_mem[6], desc_mem[7]};
        fmt   = {desc_mem[8], desc_mem[9], desc_mem[10], desc_mem[11]};
        flags = {desc_mem[12], desc_mem[13], desc_mem[14], desc_mem[15]};
        pkt   = {desc_mem[16], desc_mem[17], desc_mem[18], desc_mem[19]};
        chv   = {desc_mem[24], desc_mem[25], desc_mem[26], desc_mem[27]};
        bpc   = {desc_mem[28], desc_mem[29], desc_mem[30], desc_mem[31]};
        ex    = bits[62:52];
        man   = {1'b1, bits[51:0]};
        sh    = 6'(11'd1075 - ex);
        man_rnd = {1'b0, man} + (54'd1 << (sh - 6'd1));
        man_shr = man_rnd >> sh;
        desc_bad = (fmt != TAG_LPCM) || (flags != LpcmFlags) || (bpc != BitsPerChannel)
                || bits[63] || (ex < 11'd1023) || (ex > 11'd1054)
                || ((ex == 11'd1054) && (man > (53'hFFFF_FFFF << 21)))
                || (chv == 32'd0) || (chv > 32'd65535) || (pkt != {chv[30:0], 1'b0});
    end

    // Verdict status in check order; the modulo remainder is final by now.
    always_comb begin
        if (err_reg != ST_OK)                                st = err_reg;
        else if (phase_reg == PH_FILE)                       st = ST_BAD_SIG;
        else if (phase_reg == PH_PAYLOAD && left_reg != 64'd0) st = ST_TRUNC;
        else if (!have_reg)                                  st = ST_NO_DESC;
        else if (!seen_reg || bytes_reg == 64'd0)            st = ST_NO_SAMP;
        else if (bytes_reg[0])                               st = ST_ODD;
        else if (ch_reg == 16'd0 || rem_reg != 17'd0)        st = ST_NOT_WHOLE;
        else                                                 st = ST_OK;
    end

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        par_next   = par_reg;
        have_next  = have_reg;
        rate_next  = rate_reg;
        ch_next    = ch_reg;
        seen_next  = seen_reg;
        bytes_next = bytes_reg;
        low_next   = low_reg;
        err_next   = err_reg;
        dpend_next = dpend_reg;
        spend_next = spend_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        odata_next = odata_reg;
        okind_next = okind_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg[4:0];
        fin        = 1'b0;
        fin_len    = len_reg;

        if (cmd.clear) begin
            phase_next = PH_FILE;
            hidx_next  = 4'd0;
            tag_next   = 32'd0;
            len_next   = 64'd0;
            left_next  = 64'd0;
            pos_next   = 6'd0;
            par_next   = 1'b0;
            have_next  = 1'b0;
            rate_next  = 32'd0;
            ch_next    = 16'd0;
            seen_next  = 1'b0;
            bytes_next = 64'd0;
            low_next   = 8'd0;
            err_next   = ST_OK;
            dpend_next = 1'b0;
            spend_next = 1'b0;
        end else if (cmd.accept) begin
            spend_next = 1'b0;
            if (err_reg == ST_OK) begin
                unique case (phase_reg)
                    PH_FILE: begin
                        if (hidx_reg < 4'd4 && in_byte != sig_byte) err_next = ST_BAD_SIG;
                        hidx_next = hidx_reg + 4'd1;
                        if (hidx_reg == 4'(CafHeaderSize - 1)) begin
                            phase_next = PH_CHUNK;
                            hidx_next  = 4'd0;
                        end
                    end
                    PH_CHUNK: begin
                        if (hidx_reg < 4'd4) begin
                            tag_next = {tag_reg[23:0], in_byte};
                            if (hidx_reg == 4'd3) len_next = 64'd0;
                        end else begin
                            len_next = len_hdr;
                        end
                        hidx_next = hidx_reg + 4'd1;
                        if (hidx_reg == 4'(CafChunkHeaderSize - 1)) begin
                            left_next  = len_hdr;
                            phase_next = PH_PAYLOAD;
                            pos_next   = 6'd0;
                            par_next   = 1'b0;
                            if (tag_reg == TAG_DATA && len_hdr >= 64'(CafEditCountSize)) begin
                                seen_next  = 1'b1;
                                bytes_next = len_hdr - 64'(CafEditCountSize);
                            end
                            if (len_hdr == 64'd0) begin
                                fin     = 1'b1;
                                fin_len = len_hdr;
                            end
                        end
                    end
                    default: begin
                        if (tag_reg == TAG_DESC && !pos_reg[5]) wr_en = 1'b1;
                        if (tag_reg == TAG_DATA && pos_reg >= 6'd4) begin
                            if (!par_reg) begin
                                low_next = in_byte;
                            end else begin
                                spend_next = 1'b1;
                                okind_next = 1'b0;
                                odata_next = '0;
                                odata_next[15:0] = {in_byte, low_reg};
                                odata_next[16]   = (pos_reg == 6'd5);
                            end
                        end
                        // Position saturates past the desc size; parity keeps counting.
                        if (!pos_reg[5]) pos_next = pos_reg + 6'd1;
                        par_next  = ~par_reg;
                        left_next = left_reg - 64'd1;
                        if (left_reg == 64'd1) fin = 1'b1;
                    end
                endcase
                if (fin) begin
                    if (tag_reg == TAG_DESC) begin
                        if (fin_len < 64'(CafDescSize)) err_next = ST_BAD_DESC;
                        else dpend_next = 1'b1;
                    end else if (tag_reg == TAG_DATA && fin_len < 64'(CafEditCountSize)) begin
                        err_next = ST_SHORT;
                    end
                    phase_next = PH_CHUNK;
                    hidx_next  = 4'd0;
                end
            end
        end else if (cmd.desc_check) begin
            if (dpend_reg) begin
                dpend_next = 1'b0;
                if (desc_bad) begin
                    err_next = ST_BAD_DESC;
                end else begin
                    rate_next = man_shr[31:0];
                    ch_next   = chv[15:0];
                    have_next = 1'b1;
                end
            end
        end else if (cmd.mod_load) begin
            rem_next = 17'd0;
            quo_next = bytes_reg;
        end else if (cmd.mod_step) begin
            quo_next = {quo_reg[62:0], 1'b0};
            if (mod_t >= {1'b0, divisor}) rem_next = 17'(mod_t - {1'b0, divisor});
            else rem_next = mod_t[16:0];
        end else if (cmd.load_verdict) begin
            okind_next = 1'b1;
            odata_next = '0;
            odata_next[20:17] = st;
            if (st == ST_OK) begin
                odata_next[52:21] = rate_reg;
                odata_next[68:53] = ch_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) desc_mem[wr_addr] <= in_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FILE;
            hidx_reg  <= 4'd0;
            tag_reg   <= 32'd0;
            len_reg   <= 64'd0;
            left_reg  <= 64'd0;
            pos_reg   <= 6'd0;
            par_reg   <= 1'b0;
            have_reg  <= 1'b0;
            rate_reg  <= 32'd0;
            ch_reg    <= 16'd0;
            seen_reg  <= 1'b0;
            bytes_reg <= 64'd0;
            low_reg   <= 8'd0;
            err_reg   <= ST_OK;
            dpend_reg <= 1'b0;
            spend_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            par_reg   <= par_next;
            have_reg  <= have_next;
            rate_reg  <= rate_next;
            ch_reg    <= ch_next;
            seen_reg  <= seen_next;
            bytes_reg <= bytes_next;
            low_reg   <= low_next;
            err_reg   <= err_next;
            dpend_reg <= dpend_next;
            spend_reg <= spend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        odata_reg <= odata_next;
        okind_reg <= okind_next;
    end

    assign stat.samp_pend = spend_reg;
    assign out_kind = okind_reg;
    assign out_data = odata_reg;

endmodule

FILE: hw/rtl/caflpcm_ctrl.sv
// Controller: sequences byte intake, desc check, sample handoff, modulo and verdict.
module caflpcm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output caflpcm_pkg::cmd_t   cmd,
    input  caflpcm_pkg::stat_t  stat
);
    import caflpcm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DESC  = 3'd1;
    localparam logic [2:0] S_OUTS  = 3'd2;
    localparam logic [2:0] S_MODL  = 3'd3;
    localparam logic [2:0] S_MODS  = 3'd4;
    localparam logic [2:0] S_VLOAD = 3'd5;
    localparam logic [2:0] S_OUTV  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       valid_reg, valid_next;
    logic [5:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    last_next  = s_tlast;
                    state_next = S_DESC;
                end
            end
            S_DESC: begin
                cmd.desc_check = 1'b1;
                if (stat.samp_pend) begin
                    valid_next = 1'b1;
                    state_next = S_OUTS;
                end else if (last_reg) begin
                    state_next = S_MODL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUTS: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    state_next = last_reg ? S_MODL : S_IDLE;
                end
            end
            S_MODL: begin
                cmd.mod_load = 1'b1;
                cnt_next     = 6'd0;
                state_next   = S_MODS;
            end
            S_MODS: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) state_next = S_VLOAD;
            end
            S_VLOAD: begin
                cmd.load_verdict = 1'b1;
                valid_next       = 1'b1;
                state_next       = S_OUTV;
            end
            S_OUTV: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= 6'd0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

FILE: hw/rtl/caf_lpcm_stream_parser.sv
// CAF 16-bit linear PCM stream parser: one file byte per input beat, samples and a verdict out.
// Each byte passes through intake, then the desc check slot; a byte that completes a
// sample is handed off as an output beat before the next byte is taken. The last byte of
// a file runs a bit-serial modulo of the 64-bit data byte count by the packet size, a load
// step then shift-and-subtract steps, then the verdict is loaded and presented; after the
// verdict is taken the parse state is cleared and the next byte starts a new file. Samples
// stream out before the verdict is known.
module caf_lpcm_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] sample, [16] chunk_first, [20:17] status,
                                   // [52:21] rate, [68:53] channels, rest zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // done_res
);
    import caflpcm_pkg::*;
    `include "caf_lpcm_stream_parser_macros.svh"

    cmd_t  cmd;
    stat_t stat;
    logic  out_kind;
    logic [OutDataW-1:0] out_data;

    caflpcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    caflpcm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_byte  (s_tdata),
        .out_kind (out_kind),
        .out_data (out_data)
    );

    assign m_tdata = {3'b000, out_data};
    assign m_tuser = out_kind;
    assign m_tlast = out_kind;

    `CAF_ASSERT_IMP(a_no_intake_while_out, s_tvalid && s_tready, !m_tvalid)
    `CAF_ASSERT_IMP(a_sample_has_ok_status, m_tvalid && !m_tuser, m_tdata[52:17] == 36'd0)
    `CAF_ASSERT_NXT(a_ready_after_verdict, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the CAF 16-bit linear PCM stream parser.
`timescale 1ns / 100ps

module tb;
    import caflpcm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic        chunk_first;
        logic [3:0]  status;
        logic [31:0] rate_hz;
        logic [15:0] channels;
        logic        done_res;
    } parse_result_t;

    caf_lpcm_stream_parser u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    byte_beat_t    file_bytes[$];
    parse_result_t expected_results[$];
    int            errors = 0;
    longint        cycle_count = 0;
    bit            calm = 0;
    bit            in_taken = 0;

    // Parser state mirror.
    logic [1:0]  p_phase;
    int unsigned p_hidx;
    logic [31:0] p_tag;
    logic [63:0] p_len, p_left;
    logic [7:0]  p_desc[32];
    bit          p_have_desc, p_data_seen;
    logic [31:0] p_rate;
    logic [15:0] p_chan;
    logic [63:0] p_data_bytes;
    logic [7:0]  p_low;
    logic [3:0]  p_err;

    task automatic parser_clear();
        p_phase = PH_FILE; p_hidx = 0; p_tag = '0; p_len = '0; p_left = '0;
        foreach (p_desc[i]) p_desc[i] = '0;
        p_have_desc = 0; p_data_seen = 0; p_rate = '0; p_chan = '0;
        p_data_bytes = '0; p_low = '0; p_err = ST_OK;
    endtask

    function automatic logic [31:0] desc_word(int pos);
        return {p_desc[pos], p_desc[pos+1], p_desc[pos+2], p_desc[pos+3]};
    endfunction

    task automatic validate_desc();
        logic [63:0] bits;
        logic [31:0] ch, pkt;
        logic [10:0] ex;
        logic [63:0] man;
        int unsigned sh;
        bits = {desc_word(0), desc_word(4)};
        ch = desc_word(24);
        pkt = desc_word(16);
        ex = bits[62:52];
        man = {11'd0, 1'b1, bits[51:0]};
        if (desc_word(8) != TAG_LPCM || desc_word(12) != LpcmFlags ||
            desc_word(28) != BitsPerChannel) begin
            p_err = ST_BAD_DESC;
        end else if (bits[63] || ex < 1023 || ex > 1054 ||
                     (ex == 1054 && man > (64'hFFFF_FFFF << 21))) begin
            p_err = ST_BAD_DESC;
        end else if (ch == 0 || ch > 65535 || pkt != ch * 2) begin
            p_err = ST_BAD_DESC;
        end else begin
            sh = 1075 - ex;
            p_rate = 32'((man + (64'd1 << (sh - 1))) >> sh);
            p_chan = ch[15:0];
            p_have_desc = 1;
        end
    endtask

    task automatic close_chunk();
        if (p_tag == TAG_DESC) begin
            if (p_len < 32) p_err = ST_BAD_DESC;
            else validate_desc();
        end else if (p_tag == TAG_DATA && p_len < 4) begin
            p_err = ST_SHORT;
        end
        p_phase = PH_CHUNK;
        p_hidx = 0;
    endtask

    task automatic predict_byte(byte_beat_t bt);
        parse_result_t r;
        logic [3:0] st;
        logic [63:0] pos, s;
        if (p_err == ST_OK) begin
            if (p_phase == PH_FILE) begin
                if (p_hidx < 4 && bt.data != TAG_CAFF[31 - 8*p_hidx -: 8]) p_err = ST_BAD_SIG;
                p_hidx++;
                if (p_hidx >= CafHeaderSize) begin
                    p_phase = PH_CHUNK; p_hidx = 0;
                end
            end else if (p_phase == PH_CHUNK) begin
                if (p_hidx < 4) p_tag = {p_tag[23:0], bt.data};
                else p_len = {p_len[55:0], bt.data};
                p_hidx++;
                if (p_hidx >= CafChunkHeaderSize) begin
                    p_left = p_len;
                    p_phase = PH_PAYLOAD;
                    if (p_tag == TAG_DATA && p_len >= 4) begin
                        p_data_seen = 1; p_data_bytes = p_len - 4;
                    end
                    if (p_len == 0) close_chunk();
                end else if (p_hidx == 4) begin
                    p_len = '0;
                end
            end else begin
                pos = p_len - p_left;
                if (p_tag == TAG_DESC) begin
                    if (pos < 32) p_desc[pos[4:0]] = bt.data;
                end else if (p_tag == TAG_DATA && pos >= 4) begin
                    s = pos - 4;
                    if (!s[0]) begin
                        p_low = bt.data;
                    end else begin
                        r = '0;
                        r.sample = {bt.data, p_low};
                        r.chunk_first = (s == 1);
                        expected_results = {expected_results, r};
                    end
                end
                p_left--;
                if (p_left == 0) close_chunk();
            end
        end
        if (bt.last) begin
            st = p_err;
            if (st == ST_OK) begin
                if (p_phase == PH_FILE) st = ST_BAD_SIG;
                else if (p_phase == PH_PAYLOAD && p_left != 0) st = ST_TRUNC;
                else if (!p_have_desc) st = ST_NO_DESC;
                else if (!p_data_seen || p_data_bytes == 0) st = ST_NO_SAMP;
                else if (p_data_bytes[0]) st = ST_ODD;
                else if (p_chan == 0 || p_data_bytes % ({48'd0, p_chan} * 2) != 0)
                    st = ST_NOT_WHOLE;
            end
            r = '0;
            r.kind = 1'b1;
            r.status = st;
            r.rate_hz = (st == ST_OK) ? p_rate : '0;
            r.channels = (st == ST_OK) ? p_chan : '0;
            r.done_res = 1'b1;
            expected_results = {expected_results, r};
            parser_clear();
        end
    endtask

    // File building helpers.
    byte_beat_t file_buf[$];

    task automatic put8(logic [7:0] b);
        byte_beat_t bt;
        bt.data = b;
        bt.last = 1'b0;
        file_buf = {file_buf, bt};
    endtask

    task automatic put32(logic [31:0] w);
        for (int i = 3; i >= 0; i--) put8(w[8*i +: 8]);
    endtask

    task automatic put_chunk_head(logic [31:0] tag, logic [63:0] len);
        put32(tag); put32(len[63:32]); put32(len[31:0]);
    endtask

    task automatic put_desc(logic [63:0] rate_bits, logic [31:0] chans, logic [31:0] pkt,
                            logic [31:0] fmt, logic [31:0] flags, logic [31:0] bpc,
                            int extra);
        put_chunk_head(TAG_DESC, 64'(32 + extra));
        put32(rate_bits[63:32]); put32(rate_bits[31:0]);
        put32(fmt); put32(flags); put32(pkt); put32(32'd1); put32(chans); put32(bpc);
        repeat (extra) put8(8'($urandom));
    endtask

    task automatic put_data(int nbytes);
        put_chunk_head(TAG_DATA, 64'(4 + nbytes));
        put32(32'($urandom));
        repeat (nbytes) put8(8'($urandom));
    endtask

    task automatic flush_file();
        if (file_buf.size() == 0) put8(8'($urandom));
        file_buf[file_buf.size() - 1].last = 1'b1;
        file_bytes = {file_bytes, file_buf};
        file_buf.delete();
    endtask

    function automatic logic [63:0] rate_double(int unsigned hz);
        real r;
        r = hz;
        return $realtobits(r);
    endfunction

    task automatic good_file(logic [63:0] rbits, logic [31:0] ch, int frames);
        put32(TAG_CAFF); put32(32'h0001_0000);
        put_desc(rbits, ch, ch * 2, TAG_LPCM, LpcmFlags, BitsPerChannel, 0);
        put_data(frames * ch * 2);
        flush_file();
    endtask

    function automatic logic [63:0] random_rate_bits();
        case ($urandom_range(0, 5))
            0: return rate_double($urandom_range(1, 200000));
            1: return $realtobits($urandom_range(1, 100000) + 0.5);
            2: return $realtobits($urandom_range(1, 100000) + 0.25);
            3: return {1'b0, 11'($urandom_range(1023, 1054)), 20'($urandom), 32'($urandom)};
            4: return {$urandom, $urandom};
            default: return rate_double(44100);
        endcase
    endfunction

    task automatic random_file();
        int shape, n;
        logic [31:0] ch;
        shape = $urandom_range(0, 99);
        ch = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 6)) : 32'd1;
        if (shape < 8) begin
            n = $urandom_range(1, 30);
            repeat (n) put8(8'($urandom));
            flush_file();
            return;
        end
        put32(TAG_CAFF);
        put32($urandom);
        n = $urandom_range(0, 3);
        for (int c = 0; c < n + 2; c++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: put_desc(($urandom_range(0, 3) == 0) ? random_rate_bits() :
                                  rate_double($urandom_range(8000, 96000)),
                                  ($urandom_range(0, 9) == 0) ? $urandom : ch,
                                  ($urandom_range(0, 9) == 0) ? $urandom : ch * 2,
                                  ($urandom_range(0, 14) == 0) ? $urandom : TAG_LPCM,
                                  ($urandom_range(0, 14) == 0) ? 32'($urandom_range(0, 3))
                                                               : LpcmFlags,
                                  ($urandom_range(0, 14) == 0) ? 32'($urandom_range(8, 32))
                                                               : BitsPerChannel,
                                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
                3, 4, 5, 6: put_data(($urandom_range(0, 4) == 0) ? $urandom_range(0, 9)
                                     : ch * 2 * $urandom_range(0, 6));
                7: begin
                    put_chunk_head($urandom, 64'($urandom_range(0, 8)));
                    for (int k = 0; k < 12 && file_buf.size() > 0; k++) begin
                    end
                end
                8: begin
                    put_chunk_head(TAG_DATA, 64'($urandom_range(0, 3)));
                end
                default: begin
                    put_chunk_head(TAG_DESC, 64'($urandom_range(0, 31)));
                end
            endcase
        end
        // Append up to eight random bytes, then sometimes cut up to eleven bytes off the end.
        repeat ($urandom_range(0, 8)) put8(8'($urandom));
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 11)) void'(file_buf.pop_back());
        flush_file();
    endtask

    initial begin
        // Directed files.
        good_file(rate_double(44100), 32'd2, 3);
        good_file(rate_double(1), 32'd1, 1);
        good_file(64'h41EF_FFFF_FFE0_0000, 32'd65535, 0);   // rate 2^32-1, no samples
        good_file($realtobits(2.5), 32'd1, 2);
        put32(32'h6361_6600); flush_file();                   // bad signature
        put32(TAG_CAFF); flush_file();                        // file ends inside header
        put32(TAG_CAFF); put32(0); put_chunk_head(TAG_DATA, 64'd3); put8(0);
        put8(8'hFF); put8(8'h80); flush_file();                // short data chunk
        put32(TAG_CAFF); put32(0); put_data(4); flush_file(); // no desc
        put32(TAG_CAFF); put32(0);
        put_desc(64'h7FF0_0000_0000_0000, 1, 2, TAG_LPCM, LpcmFlags, BitsPerChannel, 0);
        flush_file();                                         // infinite rate
        put32(TAG_CAFF); put32(0); put_desc(rate_double(8000), 2, 4, TAG_LPCM,
            LpcmFlags, BitsPerChannel, 0);
        put_data(5); flush_file();                            // odd bytes, lone byte dropped
        put32(TAG_CAFF); put32(0); put_desc(rate_double(8000), 2, 4, TAG_LPCM,
            LpcmFlags, BitsPerChannel, 0);
        put_data(6); put_chunk_head(TAG_DATA, 64'd10); put8(8'h00); flush_file();
        put32(TAG_CAFF); put32(0); put_desc(rate_double(8000), 1, 2, TAG_LPCM,
            LpcmFlags, BitsPerChannel, 0);
        put_data(2); put32(TAG_DATA); flush_file();           // trailing fragment
        put8(8'hFF); put8(8'h00); flush_file();
        while (file_bytes.size() < 1150) random_file();
    end

    // Input beats are taken at the rising edge.
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) predict_byte('{data: s_tdata, last: s_tlast});
    end

    // Input driver.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (file_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
                    byte_beat_t bt;
                    bt = file_bytes[0];
                    file_bytes.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata <= bt.data;
                    s_tlast <= bt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        parse_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.sample = m_tdata[15:0];
            got.chunk_first = m_tdata[16];
            got.status = m_tdata[20:17];
            got.rate_hz = m_tdata[52:21];
            got.channels = m_tdata[68:53];
            got.done_res = m_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        calm <= (cycle_count % 20000) > 15000;
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        parser_clear();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (file_bytes.size() == 0 && !s_tvalid && cycle_count > 20);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: caf_lpcm_stream_parser.f
+incdir+hw/rtl
hw/rtl/caflpcm_pkg.sv
hw/rtl/caflpcm_dp.sv
hw/rtl/caflpcm_ctrl.sv
hw/rtl/caf_lpcm_stream_parser.sv
test/tb.sv
